// ===== sv/assert_macros.svh =====
//------------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b on the same edge
`define ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// a implies b on the next edge
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/pvd_pkg.sv =====
//------------------------------------------------------------------------------
// pvd_pkg
// Widths, head byte codes and shared types of the prefix varint decoder.
//------------------------------------------------------------------------------
package pvd_pkg;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 64;
  localparam int LEN_W   = 4;
  localparam int LANES   = VALUE_W / BYTE_W;

  localparam logic [BYTE_W-1:0] HEAD_TWO    = 8'h80;
  localparam logic [BYTE_W-1:0] HEAD_FOUR   = 8'hc0;
  localparam logic [BYTE_W-1:0] HEAD_ESCAPE = 8'hff;

  localparam logic [LEN_W-1:0] LEN_ONE    = 4'd1;
  localparam logic [LEN_W-1:0] LEN_TWO    = 4'd2;
  localparam logic [LEN_W-1:0] LEN_FOUR   = 4'd4;
  localparam logic [LEN_W-1:0] LEN_ESCAPE = 4'd9;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } byte_beat_t;

endpackage

// ===== sv/pvd_ifs.sv =====
//------------------------------------------------------------------------------
// pvd channel interfaces
// Byte input, decoded result and configuration write channels.
//------------------------------------------------------------------------------
interface pvd_byte_if;
  logic                       valid;
  logic                       ready;
  logic [pvd_pkg::BYTE_W-1:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface pvd_result_if;
  logic                        valid;
  logic                        ready;
  logic [pvd_pkg::VALUE_W-1:0] decoded_value;
  logic [pvd_pkg::LEN_W-1:0]   encoded_length;
  modport source (output valid, output decoded_value, output encoded_length, input ready);
  modport sink (input valid, input decoded_value, input encoded_length, output ready);
endinterface

interface pvd_cfg_if;
  logic valid;
  logic ready;
  logic escape_little_endian;
  modport source (output valid, output escape_little_endian, input ready);
  modport sink (input valid, input escape_little_endian, output ready);
endinterface

// ===== sv/pvd_in_stage.sv =====
//------------------------------------------------------------------------------
// pvd_in_stage
// Input register: captures one byte beat and holds it until the core takes it.
//------------------------------------------------------------------------------
module pvd_in_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [pvd_pkg::BYTE_W-1:0] in_data,
  output logic                       in_ready,
  output pvd_pkg::byte_beat_t        beat,
  input  logic                       take
);
  import pvd_pkg::*;

  logic              vld;
  logic [BYTE_W-1:0] data;

  assign in_ready   = !vld || take;
  assign beat.valid = vld;
  assign beat.data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end

endmodule

// ===== sv/pvd_core.sv =====
//------------------------------------------------------------------------------
// pvd_core
// Decode state, per-byte update and the result register.
//------------------------------------------------------------------------------
module pvd_core (
  input  logic                        clk,
  input  logic                        rst,
  input  pvd_pkg::byte_beat_t         beat,
  output logic                        take,
  input  logic                        escape_le,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pvd_pkg::VALUE_W-1:0] out_value,
  output logic [pvd_pkg::LEN_W-1:0]   out_len
);
  import pvd_pkg::*;

  logic [LEN_W-1:0]   bytes_left, bytes_left_next;
  logic               escape_mode, escape_mode_next;
  logic [VALUE_W-1:0] accumulator, accumulator_next;
  logic [LEN_W-1:0]   current_length, current_length_next;
  logic               emit;
  logic [VALUE_W-1:0] emit_value;
  logic [LEN_W-1:0]   emit_len;
  logic [2:0]         pos;
  logic [LEN_W-1:0]   left_dec;

  assign take     = beat.valid && (!out_valid || out_ready);
  assign pos      = 3'(4'd8 - bytes_left);
  assign left_dec = bytes_left - 4'd1;

  always_comb begin
    bytes_left_next     = bytes_left;
    escape_mode_next    = escape_mode;
    accumulator_next    = accumulator;
    current_length_next = current_length;
    emit                = 1'b0;
    emit_value          = {{(VALUE_W-BYTE_W){1'b0}}, beat.data};
    emit_len            = LEN_ONE;
    if (bytes_left == '0) begin
      if (beat.data < HEAD_TWO) begin
        emit = 1'b1;
      end else if (beat.data < HEAD_FOUR) begin
        accumulator_next    = {{(VALUE_W-6){1'b0}}, beat.data[5:0]};
        bytes_left_next     = 4'd1;
        current_length_next = LEN_TWO;
        escape_mode_next    = 1'b0;
      end else if (beat.data != HEAD_ESCAPE) begin
        accumulator_next    = {{(VALUE_W-6){1'b0}}, beat.data[5:0]};
        bytes_left_next     = 4'd3;
        current_length_next = LEN_FOUR;
        escape_mode_next    = 1'b0;
      end else begin
        accumulator_next    = '0;
        bytes_left_next     = 4'd8;
        current_length_next = LEN_ESCAPE;
        escape_mode_next    = 1'b1;
      end
    end else begin
      if (escape_mode && escape_le) begin
        for (int i = 0; i < LANES; i++) begin
          if (pos == 3'(i)) begin
            accumulator_next[i*BYTE_W +: BYTE_W] =
              accumulator[i*BYTE_W +: BYTE_W] | beat.data;
          end
        end
      end else begin
        accumulator_next = {accumulator[VALUE_W-BYTE_W-1:0], beat.data};
      end
      bytes_left_next = left_dec;
      if (left_dec == '0) begin
        emit                = 1'b1;
        emit_value          = accumulator_next;
        emit_len            = current_length;
        current_length_next = '0;
        escape_mode_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left     <= '0;
      escape_mode    <= 1'b0;
      current_length <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        bytes_left     <= bytes_left_next;
        escape_mode    <= escape_mode_next;
        current_length <= current_length_next;
      end
      if (take && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      accumulator <= accumulator_next;
    end
    if (take && emit) begin
      out_value <= emit_value;
      out_len   <= emit_len;
    end
  end

endmodule

// ===== sv/prefix_varint_decoder.sv =====
//------------------------------------------------------------------------------
// prefix_varint_decoder
// Decodes a byte stream of prefix-coded unsigned 64-bit integers.
//
//   channel  dir  beat contents
//   in_ch    in   in_byte
//   out_ch   out  decoded_value, encoded_length
//   cfg      in   escape_little_endian
//
// One byte per cycle sustained while out_ch is not stalled; the last byte of a
// value passes the input register, then the result register holds the result.
// A stalled result holds the core; the input register still takes one byte.
// Reset: expect a head byte, escape_little_endian = 1.
// cfg.ready is always high.
//------------------------------------------------------------------------------
module prefix_varint_decoder (
  input logic         clk,
  input logic         rst,
  pvd_byte_if.sink    in_ch,
  pvd_result_if.source out_ch,
  pvd_cfg_if.sink     cfg
);
  import pvd_pkg::*;

  byte_beat_t beat;
  logic       take;
  logic       escape_le;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_le <= 1'b1;
    end else if (cfg.valid) begin
      escape_le <= cfg.escape_little_endian;
    end
  end

  pvd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_data  (in_ch.in_byte),
    .in_ready (in_ch.ready),
    .beat     (beat),
    .take     (take)
  );

  pvd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .take      (take),
    .escape_le (escape_le),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.decoded_value),
    .out_len   (out_ch.encoded_length)
  );

endmodule

// ===== sv/pvd_checker.sv =====
//------------------------------------------------------------------------------
// pvd_checker
// Port-level checks on the decoder's result channel.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module pvd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pvd_pkg::VALUE_W-1:0] out_value,
  input logic [pvd_pkg::LEN_W-1:0]   out_len
);
  import pvd_pkg::*;

  logic stall;
  logic len_legal;
  assign stall     = out_valid && !out_ready;
  assign len_legal = out_len == LEN_ONE || out_len == LEN_TWO ||
                     out_len == LEN_FOUR || out_len == LEN_ESCAPE;

  `ASSERT_NEXT(a_hold_valid, clk, rst, stall, out_valid)
  `ASSERT_NEXT(a_hold_value, clk, rst, stall, $stable(out_value) && $stable(out_len))
  `ASSERT_SAME(a_len_legal, clk, rst, out_valid, len_legal)
  `ASSERT_SAME(a_one_range, clk, rst, out_valid && out_len == LEN_ONE, out_value[VALUE_W-1:7] == '0)
  `ASSERT_SAME(a_two_range, clk, rst, out_valid && out_len == LEN_TWO, out_value[VALUE_W-1:14] == '0)

endmodule

bind prefix_varint_decoder pvd_checker u_pvd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.decoded_value),
  .out_len   (out_ch.encoded_length)
);
